// File: hdl/i2cms_pkg.sv
package i2cms_pkg;

    localparam int MAX_MSGS = 8;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;
    localparam int LEN_W    = 16;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_NACK  = 3'd4,
        ACT_STOP  = 3'd5
    } action_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] msg_index;
        logic [6:0]       slave_address;
        logic             msg_read;
        logic [LEN_W-1:0] msg_length;
        logic [CNT_W-1:0] msg_count;
        logic             nack_seen;
        logic [7:0]       rx_in;
        logic [7:0]       tx_in;
    } req_t;

    typedef struct packed {
        action_t          action;
        logic [7:0]       line_byte;
        logic             bus_read_mode;
        logic             rx_valid;
        logic [7:0]       rx_out;
        logic [IDX_W-1:0] rx_msg;
        logic [LEN_W-1:0] rx_pos;
        logic             done_res;
        logic             error_code;
    } rsp_t;

    typedef struct packed {
        logic [6:0]       addr;
        logic             rd;
        logic [LEN_W-1:0] len;
    } desc_t;

endpackage

// File: hdl/i2c_master_message_sequencer.sv
// Combined-transfer sequencer for an I2C master over a byte-level bus engine.
// req channel (req_valid, req_stall, req_word) carries three kinds of word:
// a descriptor load into table slot msg_index, a begin that starts a transfer
// of msg_count messages, and a bus byte-complete event from the engine.
// rsp channel (rsp_valid, rsp_stall, rsp_word) returns exactly one result word
// for every accepted request word, in order: the bus action to issue, any
// received byte with its message and position, and the end-of-transfer flag
// with its error code.
// A result is registered on the edge that accepts its request. Throughput is
// one word per cycle while the receiver does not stall, limited only by the
// single result register; next-state logic works from mirror registers of
// slot 0 and of the current and next descriptor.
// While the result register holds a word and the receiver stalls, req_stall
// is high and the held result stays unchanged.
// After reset the sequencer is idle with no result pending. Table contents
// are undefined until loaded; load every slot a transfer uses before begin.
module i2c_master_message_sequencer
    import i2cms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_word,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_word
);

    logic out_valid_reg, out_valid_next;
    logic accept;

    assign req_stall = out_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    i2cms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (req_word),
        .result (rsp_word)
    );

    // hold the result while stalled, drop it once taken
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign rsp_valid = out_valid_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted word produced no result");

    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.done_res == (rsp_word.action == ACT_STOP)))
        else $error("done flag does not match stop action");

    a_error_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.error_code |-> rsp_word.done_res)
        else $error("error code without end of transfer");

    a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.rx_valid |->
            (rsp_word.action != ACT_NONE && rsp_word.action != ACT_SEND))
        else $error("received byte with no receive follow-up");

endmodule

// File: hdl/i2cms_ctrl.sv
module i2cms_ctrl
    import i2cms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t word,
    output rsp_t result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_READ,
        PH_WRITE,
        PH_STOP
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] mc_reg, mc_next;
    logic [LEN_W-1:0] bp_reg, bp_next;
    desc_t            cur_reg, nxt_reg;
    desc_t            first_reg;
    rsp_t             res_reg, res_next;

    desc_t            tbl_mem [MAX_MSGS];

    logic             last_msg;
    logic [LEN_W-1:0] bp_inc;
    logic [LEN_W-1:0] bp_eff;
    logic             more;
    logic             last_byte;
    logic             go_rd, go_wr, go_finish, go_stop, stop_err;
    logic             advance, take_first;
    desc_t            ld_desc;
    logic [CNT_W-1:0] mc_plus1;
    logic [CNT_W-1:0] far_sum;

    assign mc_plus1  = {1'b0, mc_reg} + CNT_W'(1);
    assign far_sum   = {1'b0, mc_reg} + CNT_W'(2);
    assign last_msg  = (mc_plus1 == total_reg);
    assign bp_inc    = (bp_reg != {LEN_W{1'b1}}) ? bp_reg + LEN_W'(1) : bp_reg;
    assign bp_eff    = (phase_reg == PH_READ) ? bp_inc : bp_reg;
    assign more      = (bp_eff < cur_reg.len);
    assign last_byte = ({1'b0, bp_eff} + (LEN_W+1)'(1)) == {1'b0, cur_reg.len};
    assign ld_desc   = '{addr: word.slave_address, rd: word.msg_read, len: word.msg_length};

    always_comb
    begin
        phase_next = phase_reg;
        total_next = total_reg;
        mc_next    = mc_reg;
        bp_next    = bp_reg;
        res_next   = '0;
        go_rd      = 1'b0;
        go_wr      = 1'b0;
        go_finish  = 1'b0;
        go_stop    = 1'b0;
        stop_err   = 1'b0;
        advance    = 1'b0;
        take_first = 1'b0;

        case (word.kind)
            KIND_BEGIN:
            begin
                if (phase_reg != PH_START && phase_reg != PH_READ && phase_reg != PH_WRITE &&
                    word.msg_count != '0 && word.msg_count <= CNT_W'(MAX_MSGS))
                begin
                    total_next              = word.msg_count;
                    mc_next                 = '0;
                    bp_next                 = '0;
                    phase_next              = PH_START;
                    res_next.action         = ACT_START;
                    res_next.line_byte      = {first_reg.addr, first_reg.rd};
                    res_next.bus_read_mode  = first_reg.rd;
                    take_first              = 1'b1;
                end
            end
            KIND_EVENT:
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (word.nack_seen)
                        begin
                            go_stop  = 1'b1;
                            stop_err = 1'b1;
                        end
                        else if (last_msg && bp_reg >= cur_reg.len)
                            go_stop = 1'b1;
                        else if (cur_reg.rd)
                            go_rd = 1'b1;
                        else
                            go_wr = 1'b1;
                    end
                    PH_WRITE:
                    begin
                        if (word.nack_seen)
                        begin
                            go_stop  = 1'b1;
                            stop_err = 1'b1;
                        end
                        else
                            go_wr = 1'b1;
                    end
                    PH_READ:
                    begin
                        res_next.rx_valid = 1'b1;
                        res_next.rx_out   = word.rx_in;
                        res_next.rx_msg   = mc_reg;
                        res_next.rx_pos   = bp_reg;
                        bp_next           = bp_inc;
                        go_rd             = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (go_rd)
        begin
            phase_next = PH_READ;
            if (more)
                res_next.action = last_byte ? ACT_NACK : ACT_ACK;
            else
                go_finish = 1'b1;
        end

        if (go_wr)
        begin
            phase_next = PH_WRITE;
            if (more)
            begin
                res_next.action    = ACT_SEND;
                res_next.line_byte = word.tx_in;
                bp_next            = bp_reg + LEN_W'(1);
            end
            else
                go_finish = 1'b1;
        end

        // repeated start into the next message, or stop after the last one
        if (go_finish)
        begin
            if (!last_msg)
            begin
                mc_next                = mc_reg + IDX_W'(1);
                bp_next                = '0;
                phase_next             = PH_START;
                res_next.action        = ACT_START;
                res_next.line_byte     = {nxt_reg.addr, nxt_reg.rd};
                res_next.bus_read_mode = nxt_reg.rd;
                advance                = 1'b1;
            end
            else
                go_stop = 1'b1;
        end

        if (go_stop)
        begin
            phase_next             = PH_STOP;
            res_next.action        = ACT_STOP;
            res_next.bus_read_mode = cur_reg.rd;
            res_next.done_res      = 1'b1;
            res_next.error_code    = stop_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && word.kind == KIND_LOAD)
            tbl_mem[word.msg_index] <= ld_desc;
    end

    // cur_reg and nxt_reg mirror the table at the current and the following slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            total_reg <= '0;
            mc_reg    <= '0;
            bp_reg    <= '0;
            cur_reg   <= '0;
            nxt_reg   <= '0;
            first_reg <= '0;
            res_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            total_reg <= total_next;
            mc_reg    <= mc_next;
            bp_reg    <= bp_next;
            res_reg   <= res_next;
            if (take_first)
            begin
                cur_reg <= first_reg;
                nxt_reg <= tbl_mem[IDX_W'(1)];
            end
            else if (advance)
            begin
                cur_reg <= nxt_reg;
                nxt_reg <= (far_sum < CNT_W'(MAX_MSGS)) ? tbl_mem[far_sum[IDX_W-1:0]] : '0;
            end
            else if (word.kind == KIND_LOAD)
            begin
                if (word.msg_index == mc_reg)
                    cur_reg <= ld_desc;
                if ({1'b0, word.msg_index} == mc_plus1)
                    nxt_reg <= ld_desc;
            end
            if (word.kind == KIND_LOAD && word.msg_index == '0)
                first_reg <= ld_desc;
        end
    end

    assign result = res_reg;

endmodule

// File: tb/tb_i2c_master_message_sequencer.sv
module tb_i2c_master_message_sequencer
    import i2cms_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STEP_CAP = 24;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_START,
        SQ_READ,
        SQ_WRITE,
        SQ_STOP
    } seq_phase_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_word;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_word;

    i2c_master_message_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sequencer mirror
    seq_phase_t       seq_ph = SQ_IDLE;
    logic [CNT_W-1:0] seq_total = '0;
    logic [IDX_W-1:0] seq_cur = '0;
    logic [LEN_W-1:0] seq_pos = '0;
    desc_t            desc_tbl [MAX_MSGS];

    rsp_t bus_steps_due [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_ok_ends = 0;
    int n_nack_ends = 0;

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic bit seq_busy();
        return seq_ph == SQ_START || seq_ph == SQ_READ || seq_ph == SQ_WRITE;
    endfunction

    function automatic bit on_last_msg();
        return int'(seq_cur) + 1 == int'(seq_total);
    endfunction

    function automatic void open_msg(inout rsp_t r);
        seq_ph = SQ_START;
        r.action = ACT_START;
        r.line_byte = {desc_tbl[seq_cur].addr, desc_tbl[seq_cur].rd};
        r.bus_read_mode = desc_tbl[seq_cur].rd;
    endfunction

    function automatic void close_transfer(inout rsp_t r, input bit err);
        seq_ph = SQ_STOP;
        r.action = ACT_STOP;
        r.bus_read_mode = desc_tbl[seq_cur].rd;
        r.done_res = 1'b1;
        r.error_code = err;
    endfunction

    function automatic void end_msg(inout rsp_t r);
        if (!on_last_msg())
        begin
            seq_cur++;
            seq_pos = '0;
            open_msg(r);
        end
        else
            close_transfer(r, 1'b0);
    endfunction

    function automatic void read_step(inout rsp_t r);
        seq_ph = SQ_READ;
        if (seq_pos < desc_tbl[seq_cur].len)
            r.action = (int'(seq_pos) + 1 == int'(desc_tbl[seq_cur].len)) ? ACT_NACK : ACT_ACK;
        else
            end_msg(r);
    endfunction

    function automatic void write_step(inout rsp_t r, input logic [7:0] tx);
        seq_ph = SQ_WRITE;
        if (seq_pos < desc_tbl[seq_cur].len)
        begin
            r.action = ACT_SEND;
            r.line_byte = tx;
            seq_pos++;
        end
        else
            end_msg(r);
    endfunction

    function automatic rsp_t next_bus_step(req_t w);
        rsp_t r;
        r = '0;
        case (w.kind)
            KIND_LOAD:
                if (int'(w.msg_index) < MAX_MSGS)
                    desc_tbl[w.msg_index] = {w.slave_address, w.msg_read, w.msg_length};
            KIND_BEGIN:
                if (!seq_busy() && w.msg_count >= 1 && int'(w.msg_count) <= MAX_MSGS)
                begin
                    seq_total = w.msg_count;
                    seq_cur = '0;
                    seq_pos = '0;
                    open_msg(r);
                end
            KIND_EVENT:
                case (seq_ph)
                    SQ_START:
                        if (w.nack_seen)
                            close_transfer(r, 1'b1);
                        else if (on_last_msg() && seq_pos >= desc_tbl[seq_cur].len)
                            close_transfer(r, 1'b0);
                        else if (desc_tbl[seq_cur].rd)
                            read_step(r);
                        else
                            write_step(r, w.tx_in);
                    SQ_WRITE:
                        if (w.nack_seen)
                            close_transfer(r, 1'b1);
                        else
                            write_step(r, w.tx_in);
                    SQ_READ:
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_out = w.rx_in;
                        r.rx_msg = seq_cur;
                        r.rx_pos = seq_pos;
                        if (seq_pos != '1)
                            seq_pos++;
                        read_step(r);
                    end
                    default: ;
                endcase
            default: ;
        endcase
        return r;
    endfunction

    function automatic req_t rand_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(req_t)-1:0];
    endfunction

    function automatic req_t load_word(int slot, int addr, int rd, int len);
        req_t w;
        w = rand_word();
        w.kind = KIND_LOAD;
        w.msg_index = IDX_W'(slot);
        w.slave_address = 7'(addr);
        w.msg_read = 1'(rd);
        w.msg_length = LEN_W'(len);
        return w;
    endfunction

    function automatic req_t begin_word(int cnt);
        req_t w;
        w = rand_word();
        w.kind = KIND_BEGIN;
        w.msg_count = CNT_W'(cnt);
        return w;
    endfunction

    function automatic req_t event_word(int nack, int rx, int tx);
        req_t w;
        w = rand_word();
        w.kind = KIND_EVENT;
        w.nack_seen = 1'(nack);
        w.rx_in = 8'(rx);
        w.tx_in = 8'(tx);
        return w;
    endfunction

    function automatic string show_step(rsp_t r);
        return $sformatf("act=%0d byte=%02h rdm=%0b rxv=%0b rx=%02h msg=%0d pos=%0d done=%0b err=%0b",
                         r.action, r.line_byte, r.bus_read_mode, r.rx_valid, r.rx_out,
                         r.rx_msg, r.rx_pos, r.done_res, r.error_code);
    endfunction

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        string bad;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_word.done_res === 1'b1)
            begin
                if (rsp_word.error_code === 1'b1)
                    n_nack_ends++;
                else
                    n_ok_ends++;
            end
            if (bus_steps_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word: %s", show_step(rsp_word));
            end
            else
            begin
                want = bus_steps_due.pop_front();
                n_checked++;
                bad = "";
                if (rsp_word.action !== want.action)               bad = {bad, " action"};
                if (rsp_word.line_byte !== want.line_byte)         bad = {bad, " line_byte"};
                if (rsp_word.bus_read_mode !== want.bus_read_mode) bad = {bad, " bus_read_mode"};
                if (rsp_word.rx_valid !== want.rx_valid)           bad = {bad, " rx_valid"};
                if (rsp_word.rx_out !== want.rx_out)               bad = {bad, " rx_out"};
                if (rsp_word.rx_msg !== want.rx_msg)               bad = {bad, " rx_msg"};
                if (rsp_word.rx_pos !== want.rx_pos)               bad = {bad, " rx_pos"};
                if (rsp_word.done_res !== want.done_res)           bad = {bad, " done_res"};
                if (rsp_word.error_code !== want.error_code)       bad = {bad, " error_code"};
                if (bad != "")
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch on%s at result %0d\n  expected %s\n  actual   %s",
                                 bad, n_checked, show_step(want), show_step(rsp_word));
                end
            end
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_word(input req_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        bus_steps_due.push_back(next_bus_step(w));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(negedge clk);
        while (bus_steps_due.size() != 0)
            @(negedge clk);
    endtask

    // every slot gets written here, so no transfer ever reads an unloaded descriptor
    task automatic test_table_load();
        send_word(load_word(0, 7'h7F, 1'b0, 2));
        send_word(load_word(1, 7'h00, 1'b1, 2));
        send_word(load_word(2, 7'h55, 1'b0, 0));
        send_word(load_word(3, 7'h2A, 1'b1, 0));
        send_word(load_word(4, 7'h33, 1'b1, 1));
        send_word(load_word(5, 7'h01, 1'b0, 16'hFFFF));
        send_word(load_word(6, 7'h40, 1'b1, 1));
        send_word(load_word(7, 7'h4C, 1'b0, 1));
    endtask

    task automatic test_ignored_words();
        req_t w;
        send_word(event_word(1'b1, 8'hFF, 8'hFF));
        send_word(begin_word(0));
        send_word(begin_word(15));
        w = rand_word();
        w.kind = KIND_UNUSED;
        send_word(w);
    endtask

    // write, read, then two empty messages: the first empty one goes straight to a repeated start
    task automatic test_combined_transfer();
        send_word(begin_word(4));
        send_word(event_word(1'b0, 8'h00, 8'hFF));
        send_word(begin_word(1));
        send_word(event_word(1'b0, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'hFF, 8'h00));
        send_word(event_word(1'b1, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'h00, 8'h00));
    endtask

    task automatic test_address_and_data_nack();
        send_word(begin_word(1));
        send_word(event_word(1'b1, 8'h00, 8'h00));
        send_word(begin_word(1));
        send_word(event_word(1'b0, 8'h00, 8'hA5));
        send_word(event_word(1'b1, 8'h00, 8'h00));
    endtask

    // shrink a long read while it runs
    task automatic test_reload_while_busy();
        send_word(load_word(0, 7'h7F, 1'b1, 16'hFFFF));
        send_word(begin_word(1));
        send_word(event_word(1'b0, 8'h00, 8'h00));
        send_word(event_word(1'b0, 8'h5A, 8'h00));
        send_word(load_word(0, 7'h7F, 1'b1, 2));
        send_word(event_word(1'b0, 8'hC3, 8'h00));
    endtask

    task automatic run_transfer();
        int cnt;
        int steps;
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_MSGS) : $urandom_range(1, 3);
        if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < cnt; i++)
                send_word(load_word(i, $urandom_range(0, 127), $urandom_range(0, 1),
                                    ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 4)));
        send_word(begin_word(cnt));
        steps = 0;
        while (seq_busy())
        begin
            if (steps >= STEP_CAP)
            begin
                // cut a long message short: empty the running read, nack anything else
                if (seq_ph == SQ_READ)
                    send_word(load_word(seq_cur, $urandom_range(0, 127), $urandom_range(0, 1), 0));
                send_word(event_word(1'b1, $urandom_range(0, 255), $urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                    send_word(load_word($urandom_range(0, MAX_MSGS - 1), $urandom_range(0, 127),
                                        $urandom_range(0, 1), $urandom_range(0, 4)));
                else
                    send_word(begin_word($urandom_range(0, 15)));
            end
            else
                send_word(event_word($urandom_range(0, 11) == 0, $urandom_range(0, 255),
                                     $urandom_range(0, 255)));
            steps++;
        end
        if ($urandom_range(0, 3) == 0)
            send_word(event_word($urandom_range(0, 1), $urandom_range(0, 255),
                                 $urandom_range(0, 255)));
    endtask

    task automatic test_random();
        int idle_by_phase [4];
        int stall_by_phase [4];
        int stop_at;
        req_t w;
        idle_by_phase = '{0, 76, 0, 13};
        stall_by_phase = '{0, 0, 76, 13};
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            send_idle_pct = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            stop_at = n_sent + 100;
            while (n_sent < stop_at)
            begin
                if ($urandom_range(0, 99) < 85)
                    run_transfer();
                else
                begin
                    w = rand_word();
                    w.kind = 2'($urandom_range(0, 3));
                    send_word(w);
                end
            end
        end
    endtask

    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req_word <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_load();
        test_ignored_words();
        test_combined_transfer();
        test_address_and_data_nack();
        test_reload_while_busy();
        wait_idle();
        test_random();

        wait_idle();
        repeat (5) @(posedge clk);
        n_errors += bus_steps_due.size();

        $display("Sent %0d words and checked %0d result words over four handshake pressure mixes",
                 n_sent, n_checked);
        $display("Transfers ended cleanly %0d times and on a missing ack %0d times",
                 n_ok_ends, n_nack_ends);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/i2cms_pkg.sv
hdl/i2cms_ctrl.sv
hdl/i2c_master_message_sequencer.sv
tb/tb_i2c_master_message_sequencer.sv
